FILE: hw/rtl/djd_pkg.sv
`timescale 1ns / 1ps

package djd_pkg;

   localparam int PENDING_DEPTH_DEF = 16;

   localparam int CMD_W   = 2;
   localparam int TIME_W  = 17;
   localparam int JOB_W   = 16;
   localparam int FILE_W  = 16;
   localparam int DELAY_W = 16;
   localparam int DUE_W   = 18;
   localparam int TURN_W  = 18;
   localparam int KIND_W  = 2;
   localparam int NODES_W = 4;

   localparam int REQ_FIELDS_W = TIME_W + JOB_W + FILE_W + DELAY_W + TIME_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = JOB_W + FILE_W + TIME_W + TIME_W + TURN_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONFIRM = 2'd2;

   localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FINISH   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd2;

   localparam logic [NODES_W-1:0] NODES_RESET = 4'd15;

   typedef struct packed {
      logic [JOB_W-1:0]  job;
      logic [FILE_W-1:0] file;
      logic [DUE_W-1:0]  due;
   } entry_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [JOB_W-1:0]  job;
      logic [FILE_W-1:0] file;
      logic [TIME_W-1:0] begin_time;
      logic [TIME_W-1:0] end_time;
      logic [TURN_W-1:0] turnaround;
   } result_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic shift;
      logic sel_disp;
   } ctrl_type;

   typedef struct packed {
      logic hit;
      logic scan_done;
      logic shift_done;
      logic first_vld;
      logic disp_vld;
   } stat_type;

endpackage

FILE: hw/rtl/djd_ctrl.sv
`timescale 1ns / 1ps

module djd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic               rsp_tlast,
   output djd_pkg::ctrl_type  ctrl,
   input  djd_pkg::stat_type  stat
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_SHIFT = 6'b001000,
      ST_OUT1  = 6'b010000,
      ST_OUT2  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.hit) begin
               state_in = ST_SHIFT;
            end else if (stat.scan_done) begin
               state_in = stat.first_vld ? ST_OUT1 : ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (stat.shift_done) state_in = stat.first_vld ? ST_OUT1 : ST_OUT2;
         end
         ST_OUT1: begin
            if (rsp_tready) state_in = stat.disp_vld ? ST_OUT2 : ST_IDLE;
         end
         ST_OUT2: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready    = (state_ff == ST_IDLE);
   assign rsp_tvalid    = (state_ff == ST_OUT1) || (state_ff == ST_OUT2);
   assign rsp_tlast     = (state_ff == ST_OUT2) || !stat.disp_vld;

   assign ctrl.load     = (state_ff == ST_IDLE) && req_tvalid;
   assign ctrl.exec     = (state_ff == ST_EXEC);
   assign ctrl.scan     = (state_ff == ST_SCAN);
   assign ctrl.shift    = (state_ff == ST_SHIFT);
   assign ctrl.sel_disp = (state_ff == ST_OUT2);

endmodule

FILE: hw/rtl/djd_dpath.sv
`timescale 1ns / 1ps

module djd_dpath #(
   parameter int PENDING_DEPTH = djd_pkg::PENDING_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  djd_pkg::ctrl_type                 ctrl,
   output djd_pkg::stat_type                 stat,
   input  logic [djd_pkg::CMD_W-1:0]         in_command,
   input  logic [djd_pkg::TIME_W-1:0]        in_time,
   input  logic [djd_pkg::JOB_W-1:0]         in_job,
   input  logic [djd_pkg::FILE_W-1:0]        in_file,
   input  logic [djd_pkg::DELAY_W-1:0]       in_delay,
   input  logic [djd_pkg::TIME_W-1:0]        in_stamp,
   input  logic                              csr_valid,
   input  logic [djd_pkg::NODES_W-1:0]       csr_wdata,
   output djd_pkg::result_type               result
);

   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

   djd_pkg::entry_type mem [PENDING_DEPTH];
   djd_pkg::entry_type rdata_ff;

   logic [djd_pkg::CMD_W-1:0]   cmd_ff;
   logic [djd_pkg::TIME_W-1:0]  now_ff;
   logic [djd_pkg::JOB_W-1:0]   job_ff;
   logic [djd_pkg::FILE_W-1:0]  file_ff;
   logic [djd_pkg::DELAY_W-1:0] delay_ff;
   logic [djd_pkg::TIME_W-1:0]  stamp_ff;

   logic [CW-1:0]                count_ff;
   logic                         busy_ff;
   logic [djd_pkg::NODES_W-1:0]  confirm_ff;
   logic [djd_pkg::NODES_W-1:0]  confirm_in;
   logic [djd_pkg::NODES_W-1:0]  nodes_ff;

   logic [CW-1:0] scan_ff;
   logic [CW-1:0] chk_idx_ff;
   logic          chk_vld_ff;
   logic [CW-1:0] sr_ff;
   logic [AW-1:0] sh_ff;
   logic          wv_ff;

   djd_pkg::result_type first_ff;
   djd_pkg::result_type disp_ff;
   logic                first_vld_ff;
   logic                disp_vld_ff;

   logic [CW-1:0]      rd_ptr;
   logic               we;
   logic [AW-1:0]      waddr;
   djd_pkg::entry_type wdata;
   logic               add_ok;
   logic               issue_more;
   logic               shift_more;
   logic               hit;
   logic [djd_pkg::DUE_W-1:0] due_new;

   assign add_ok     = (count_ff < DEPTH_C);
   assign issue_more = (scan_ff < count_ff);
   assign shift_more = (sr_ff < count_ff);
   assign due_new    = djd_pkg::DUE_W'(now_ff) + djd_pkg::DUE_W'(delay_ff);
   assign confirm_in = confirm_ff + 1'b1;
   assign hit        = !busy_ff && chk_vld_ff
                       && (rdata_ff.due <= djd_pkg::DUE_W'(now_ff));

   assign stat.hit        = ctrl.scan && hit;
   assign stat.scan_done  = busy_ff || (!hit && !issue_more);
   assign stat.shift_done = !shift_more && !wv_ff;
   assign stat.first_vld  = first_vld_ff;
   assign stat.disp_vld   = disp_vld_ff;

   assign result = ctrl.sel_disp ? disp_ff : first_ff;

   assign rd_ptr = ctrl.shift ? sr_ff : scan_ff;

   always_comb begin
      we    = 1'b0;
      waddr = count_ff[AW-1:0];
      wdata = '{job: job_ff, file: file_ff, due: due_new};
      if (ctrl.exec && (cmd_ff == djd_pkg::CMD_ADD) && add_ok) begin
         we = 1'b1;
      end else if (ctrl.shift && wv_ff) begin
         we    = 1'b1;
         waddr = sh_ff;
         wdata = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[rd_ptr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff   <= in_command;
         now_ff   <= in_time;
         job_ff   <= in_job;
         file_ff  <= in_file;
         delay_ff <= in_delay;
         stamp_ff <= in_stamp;
      end
      if (ctrl.exec) begin
         scan_ff  <= '0;
         if (cmd_ff == djd_pkg::CMD_CONFIRM) begin
            first_ff <= '{kind: djd_pkg::KIND_FINISH, job: job_ff, file: '0,
                          begin_time: stamp_ff, end_time: now_ff,
                          turnaround: djd_pkg::TURN_W'(now_ff)
                                      - djd_pkg::TURN_W'(stamp_ff)};
         end else begin
            first_ff <= '{kind: djd_pkg::KIND_REJECT, job: job_ff, file: file_ff,
                          begin_time: '0, end_time: '0, turnaround: '0};
         end
      end
      if (ctrl.scan && !busy_ff) begin
         scan_ff    <= scan_ff + 1'b1;
         chk_idx_ff <= scan_ff;
      end
      if (ctrl.scan && hit) begin
         disp_ff <= '{kind: djd_pkg::KIND_DISPATCH, job: rdata_ff.job,
                      file: rdata_ff.file, begin_time: now_ff, end_time: '0,
                      turnaround: '0};
         sh_ff   <= chk_idx_ff[AW-1:0];
         sr_ff   <= chk_idx_ff + 1'b1;
      end
      if (ctrl.shift) begin
         if (shift_more) sr_ff <= sr_ff + 1'b1;
         if (wv_ff) sh_ff <= sh_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         confirm_ff   <= '0;
         nodes_ff     <= djd_pkg::NODES_RESET;
         chk_vld_ff   <= 1'b0;
         wv_ff        <= 1'b0;
         first_vld_ff <= 1'b0;
         disp_vld_ff  <= 1'b0;
      end else begin
         if (csr_valid) nodes_ff <= csr_wdata;
         if (ctrl.load) begin
            first_vld_ff <= 1'b0;
            disp_vld_ff  <= 1'b0;
         end
         if (ctrl.exec) begin
            chk_vld_ff <= 1'b0;
            if (cmd_ff == djd_pkg::CMD_ADD) begin
               if (add_ok) begin
                  count_ff <= count_ff + 1'b1;
               end else begin
                  first_vld_ff <= 1'b1;
               end
            end else if (cmd_ff == djd_pkg::CMD_CONFIRM) begin
               if (confirm_in == nodes_ff) begin
                  busy_ff      <= 1'b0;
                  confirm_ff   <= '0;
                  first_vld_ff <= 1'b1;
               end else begin
                  confirm_ff <= confirm_in;
               end
            end
         end
         if (ctrl.scan && !busy_ff) begin
            chk_vld_ff <= issue_more;
         end
         if (ctrl.scan && hit) begin
            busy_ff     <= 1'b1;
            disp_vld_ff <= 1'b1;
            wv_ff       <= 1'b0;
         end
         if (ctrl.shift) begin
            wv_ff <= shift_more;
            if (!shift_more && !wv_ff) count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/delayed_job_dispatcher.sv
`timescale 1ns / 1ps

// Delayed job dispatcher. Each req transfer (tuser = command) adds a job with
// a due time, counts a completion confirmation, or only ticks the clock; the
// block then sends zero, one or two rsp transfers, tlast on the final one. A
// rejection or finished record goes out before a dispatch of the same item.
// One item is worked at a time. An item loads and applies the command, then
// scans the pending table through its single read port at one entry per
// cycle (through every entry with no due entry, up to the first due entry on
// a hit, or with no read while busy), on a dispatch compacts the table over
// the same port, and then sends its results as rsp_tready takes them. The
// nodes_required register is to be written on the csr channel only while
// idle; the block itself does not enforce this, and the register resets to
// 15.
module delayed_job_dispatcher #(
   parameter int PENDING_DEPTH = djd_pkg::PENDING_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // current_time, job_id, file_tag, delay_secs, start_stamp
   input  logic [djd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // command
   input  logic [djd_pkg::CMD_W-1:0]           req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // out_job, out_file, begin_time, end_time, turnaround
   output logic [djd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // result_kind
   output logic [djd_pkg::KIND_W-1:0]          rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [djd_pkg::NODES_W-1:0]         csr_wdata,
   input  logic                                csr_valid,
   output logic                                csr_ready
);

   localparam int T0 = 0;
   localparam int J0 = T0 + djd_pkg::TIME_W;
   localparam int F0 = J0 + djd_pkg::JOB_W;
   localparam int D0 = F0 + djd_pkg::FILE_W;
   localparam int S0 = D0 + djd_pkg::DELAY_W;

   djd_pkg::ctrl_type   ctrl;
   djd_pkg::stat_type   stat;
   djd_pkg::result_type result;

   assign csr_ready = 1'b1;

   djd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .ctrl       (ctrl),
      .stat       (stat)
   );

   djd_dpath #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .in_command (req_tuser),
      .in_time    (req_tdata[J0-1:T0]),
      .in_job     (req_tdata[F0-1:J0]),
      .in_file    (req_tdata[D0-1:F0]),
      .in_delay   (req_tdata[S0-1:D0]),
      .in_stamp   (req_tdata[S0+djd_pkg::TIME_W-1:S0]),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .result     (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tdata = djd_pkg::RSP_DATA_W'({result.turnaround, result.end_time,
                                            result.begin_time, result.file,
                                            result.job});

endmodule
